// ----- rtl/htwd_pkg.sv -----
`default_nettype none
package htwd_pkg;

	localparam int NODE_W        = 9;
	localparam int SYM_W         = 8;
	localparam int BITS_PER_BYTE = 8;
	localparam int POS_W         = 3;
	localparam int CNT_W         = 4;

	// Item operation codes
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_DATA  = 2'd1;
	localparam logic [1:0] OP_FINAL = 2'd2;

	typedef struct packed {
		logic [1:0]        op;
		logic [NODE_W-1:0] node_index;
		logic [NODE_W-1:0] child_zero;
		logic [NODE_W-1:0] child_one;
		logic              is_leaf;
		logic [SYM_W-1:0]  leaf_symbol;
		logic [SYM_W-1:0]  data_byte;
		logic [POS_W-1:0]  bit_high;
		logic [POS_W-1:0]  bit_low;
	} code_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
	} sym_item_t;

	// One node table entry
	typedef struct packed {
		logic [NODE_W-1:0] child_zero;
		logic [NODE_W-1:0] child_one;
		logic              is_leaf;
		logic [SYM_W-1:0]  symbol;
	} node_t;

	typedef struct packed {
		logic              en;
		logic [NODE_W-1:0] idx;
		node_t             node;
	} wr_req_t;

	typedef struct packed {
		logic      valid;
		sym_item_t item;
	} emit_t;

endpackage
`default_nettype wire

// ----- rtl/huffman_tree_walk_decoder.sv -----
// Huffman tree-walk decoder.
// Input channel code_valid/code_stall/code: op 0 items load one node of the
// code tree (node 0 is the root); op 1 items carry one coded byte whose bits
// bit_high down to bit_low are walked; op 2 items do the same and then flush
// a leaf that is still pending.
// Output channel sym_valid/sym_stall/sym: one decoded symbol per item, with
// last set on the final symbol caused by one input item.
// A data item's walk can be held up while the receiver stalls; the walk
// reads one table node per bit through the node memory's single
// registered read port, and each read depends on the node before it. One
// item is in work at a time: after a data item is accepted, code_stall is
// high until the item's last symbol has been handed to the output register.
// Reset returns the walk to the root and drops any held symbol; the node
// table keeps no reset and must be loaded before it is walked.
// While sym_stall is high the output register holds its item; the walk
// goes on holding a second symbol and waits once a further one is ready.
`default_nettype none
module huffman_tree_walk_decoder
	import htwd_pkg::*;
#(
	parameter int MAX_NODES = 512
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       code_valid,
	output logic            code_stall,
	input  wire code_item_t code,
	output logic            sym_valid,
	input  wire logic       sym_stall,
	output sym_item_t       sym
);

	logic              out_valid_q;
	sym_item_t         out_q;
	logic              out_free;
	node_t             entry;
	node_t             root;
	logic [NODE_W-1:0] rd_node;
	wr_req_t           wr;
	emit_t             emit;

	htwd_node_mem #(
		.MAX_NODES(MAX_NODES)
	) u_mem (
		.clk     (clk),
		.wr      (wr),
		.rd_node (rd_node),
		.entry   (entry),
		.root    (root)
	);

	htwd_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code       (code),
		.entry      (entry),
		.root       (root),
		.out_free   (out_free),
		.rd_node    (rd_node),
		.wr         (wr),
		.emit       (emit)
	);

	assign out_free = !out_valid_q || !sym_stall;

	// Output register: load a released symbol, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (!sym_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_q <= emit.item;
		end
	end

	assign sym_valid = out_valid_q;
	assign sym       = out_q;

endmodule
`default_nettype wire

// ----- rtl/htwd_node_mem.sv -----
`default_nettype none
module htwd_node_mem
	import htwd_pkg::*;
#(
	parameter int MAX_NODES = 512
) (
	input  wire logic              clk,
	input  wire wr_req_t           wr,
	input  wire logic [NODE_W-1:0] rd_node,
	output node_t                  entry,
	output node_t                  root
);

	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int EW = (AW > NODE_W) ? AW : NODE_W;

	node_t         node_ram_q [MAX_NODES];
	node_t         rdata_q;
	logic          oor_q;
	node_t         root_q;
	logic [EW-1:0] wr_ext;
	logic [EW-1:0] rd_ext;
	logic          wr_in_range;
	logic          rd_in_range;

	assign wr_ext      = EW'(wr.idx);
	assign rd_ext      = EW'(rd_node);
	assign wr_in_range = 32'(wr_ext) < MAX_NODES;
	assign rd_in_range = 32'(rd_ext) < MAX_NODES;

	// Write a loaded entry, drop loads beyond the table
	always_ff @(posedge clk) begin
		if (wr.en && wr_in_range) begin
			node_ram_q[wr_ext[AW-1:0]] <= wr.node;
		end
	end

	// Read one node per cycle, remember whether it lies beyond the table
	always_ff @(posedge clk) begin
		if (rd_in_range) begin
			rdata_q <= node_ram_q[rd_ext[AW-1:0]];
		end
		oor_q <= !rd_in_range;
	end

	// Keep a copy of the root so a leaf return needs no second read
	always_ff @(posedge clk) begin
		if (wr.en && wr.idx == '0) begin
			root_q <= wr.node;
		end
	end

	assign entry = oor_q ? '0 : rdata_q;
	assign root  = root_q;

endmodule
`default_nettype wire

// ----- rtl/htwd_walk.sv -----
`default_nettype none
module htwd_walk
	import htwd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              code_valid,
	output logic                   code_stall,
	input  wire code_item_t        code,
	input  wire node_t             entry,
	input  wire node_t             root,
	input  wire logic              out_free,
	output logic [NODE_W-1:0]      rd_node,
	output wr_req_t                wr,
	output emit_t                  emit
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]               state_q;
	logic [NODE_W-1:0]        cur_q;
	logic [NODE_W-1:0]        cur_d;
	logic [BITS_PER_BYTE-1:0] shift_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     final_q;
	logic                     pend_valid_q;
	logic [SYM_W-1:0]         pend_sym_q;

	logic                     accept;
	logic                     is_data;
	node_t                    eff;
	logic [NODE_W-1:0]        next_node;
	logic                     bits_left;
	logic                     need_emit;
	logic                     blocked;
	logic                     advance;
	logic [CNT_W-1:0]         span;

	assign code_stall = (state_q != ST_IDLE);
	assign accept     = (state_q == ST_IDLE) && code_valid;
	assign is_data    = (code.op == OP_DATA) || (code.op == OP_FINAL);

	// Leaf emits and the walk restarts from the root before the bit
	assign eff       = entry.is_leaf ? root : entry;
	assign next_node = shift_q[BITS_PER_BYTE-1] ? eff.child_one : eff.child_zero;
	assign bits_left = (cnt_q != '0);
	assign need_emit = entry.is_leaf && (bits_left || final_q);
	assign blocked   = need_emit && pend_valid_q && !out_free;
	assign advance   = (state_q == ST_WALK) && !blocked;

	assign span = (code.bit_low <= code.bit_high)
		? ({1'b0, code.bit_high} - {1'b0, code.bit_low} + CNT_W'(1)) : '0;

	// Next node; the memory reads it so its entry is ready next cycle
	always_comb begin
		cur_d = cur_q;
		if (advance) begin
			if (bits_left) begin
				cur_d = next_node;
			end else if (need_emit) begin
				cur_d = '0;
			end
		end
	end
	assign rd_node = cur_d;

	// Table load request
	always_comb begin
		wr.en              = accept && (code.op == OP_LOAD);
		wr.idx             = code.node_index;
		wr.node.child_zero = code.child_zero;
		wr.node.child_one  = code.child_one;
		wr.node.is_leaf    = code.is_leaf;
		wr.node.symbol     = code.leaf_symbol;
	end

	// Release the held symbol once a newer one or the item end is known
	always_comb begin
		emit.valid       = 1'b0;
		emit.item.symbol = pend_sym_q;
		emit.item.last   = 1'b0;
		if (advance && need_emit && pend_valid_q) begin
			emit.valid = 1'b1;
		end else if (state_q == ST_DONE && pend_valid_q && out_free) begin
			emit.valid     = 1'b1;
			emit.item.last = 1'b1;
		end
	end

	// Sequencer, bit shifter and held symbol
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_q        <= '0;
			cnt_q        <= '0;
			final_q      <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			cur_q <= cur_d;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && is_data) begin
						cnt_q   <= span;
						final_q <= (code.op == OP_FINAL);
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (advance) begin
						if (need_emit) begin
							pend_valid_q <= 1'b1;
						end
						if (bits_left) begin
							cnt_q <= cnt_q - CNT_W'(1);
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload: shift the coded bits out MSB first, hold the newest symbol
	always_ff @(posedge clk) begin
		if (accept && is_data) begin
			shift_q <= code.data_byte << (~code.bit_high);
		end else if (advance && bits_left) begin
			shift_q <= shift_q << 1;
		end
		if (advance && need_emit) begin
			pend_sym_q <= entry.symbol;
		end
	end

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
class symbol_scoreboard;
	htwd_pkg::node_t     tree_nodes [1 << htwd_pkg::NODE_W];
	logic [htwd_pkg::NODE_W-1:0] walk_node;
	htwd_pkg::sym_item_t pending_syms [$];
	int                  errors;

	function new();
		walk_node = '0;
		errors    = 0;
	endfunction

	task report(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	function int pending();
		return pending_syms.size();
	endfunction

	// Walk the tree for one accepted item and queue the symbols it yields
	function void note_code(htwd_pkg::code_item_t it);
		htwd_pkg::node_t     nd;
		htwd_pkg::sym_item_t found [$];
		htwd_pkg::sym_item_t s;
		int                  pos;
		int                  lo;
		case (it.op)
		htwd_pkg::OP_LOAD: begin
			nd.child_zero = it.child_zero;
			nd.child_one  = it.child_one;
			nd.is_leaf    = it.is_leaf;
			nd.symbol     = it.leaf_symbol;
			tree_nodes[it.node_index] = nd;
		end
		htwd_pkg::OP_DATA, htwd_pkg::OP_FINAL: begin
			lo = it.bit_low;
			for (pos = it.bit_high; pos >= lo; pos--) begin
				nd = tree_nodes[walk_node];
				// a leaf pays out before the next bit, then the walk restarts at the root
				if (nd.is_leaf) begin
					s.symbol = nd.symbol;
					s.last   = 1'b0;
					found.push_back(s);
					walk_node = '0;
					nd = tree_nodes[0];
				end
				walk_node = it.data_byte[pos] ? nd.child_one : nd.child_zero;
			end
			// flush a pending leaf on a final byte
			if (it.op == htwd_pkg::OP_FINAL) begin
				nd = tree_nodes[walk_node];
				if (nd.is_leaf) begin
					s.symbol = nd.symbol;
					s.last   = 1'b0;
					found.push_back(s);
					walk_node = '0;
				end
			end
			if (found.size() > 0) begin
				s = found.pop_back();
				s.last = 1'b1;
				found.push_back(s);
			end
			foreach (found[k])
				pending_syms.push_back(found[k]);
		end
		default: ;
		endcase
	endfunction

	// Compare one accepted symbol with the oldest one waiting
	task check_symbol(htwd_pkg::sym_item_t got);
		htwd_pkg::sym_item_t want;
		if (pending_syms.size() == 0) begin
			report($sformatf("symbol %02h last %b with none waiting", got.symbol, got.last));
		end else begin
			want = pending_syms.pop_front();
			if (got.symbol !== want.symbol)
				report($sformatf("symbol %02h, want %02h", got.symbol, want.symbol));
			if (got.last !== want.last)
				report($sformatf("last %b on symbol %02h, want %b", got.last, got.symbol,
					want.last));
		end
	endtask
endclass

module testbench;
	import htwd_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         CYCLE_LIMIT = 200000;
	localparam int         LONG_HOLD   = 400;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       code_valid;
	logic       code_stall;
	code_item_t code;
	logic       sym_valid;
	logic       sym_stall;
	sym_item_t  sym;

	symbol_scoreboard sb;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_req       = 0;
	int hold_ack       = 0;
	int hold_left      = 0;
	int cycles         = 0;
	int sent_items     = 0;

	bit node_loaded [1 << NODE_W];
	int loaded_list [$];

	huffman_tree_walk_decoder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code       (code),
		.sym_valid  (sym_valid),
		.sym_stall  (sym_stall),
		.sym        (sym)
	);

	always #1 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** huffman_tree_walk_decoder: FAILED **");
			$finish;
		end
	end

	// Check every symbol taken from the block
	always @(posedge clk) begin
		if (arst_n && sym_valid && !sym_stall)
			sb.check_symbol(sym);
	end

	// Drive the symbol-side stall: random stalls, or a long hold-off when asked
	initial begin
		sym_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				sym_stall <= 1'b1;
			end else if (hold_ack != hold_req) begin
				hold_ack  = hold_req;
				hold_left = LONG_HOLD - 1;
				sym_stall <= 1'b1;
			end else begin
				sym_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	function automatic code_item_t random_fill();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[$bits(code_item_t)-1:0];
	endfunction

	function automatic code_item_t load_item(int idx, int c0, int c1, bit leaf, int symb);
		code_item_t it;
		it             = random_fill();
		it.op          = OP_LOAD;
		it.node_index  = NODE_W'(idx);
		it.child_zero  = NODE_W'(c0);
		it.child_one   = NODE_W'(c1);
		it.is_leaf     = leaf;
		it.leaf_symbol = SYM_W'(symb);
		if (!node_loaded[idx]) begin
			node_loaded[idx] = 1'b1;
			loaded_list.push_back(idx);
		end
		return it;
	endfunction

	function automatic code_item_t data_item(logic [1:0] op, int b, int hi, int lo);
		code_item_t it;
		it           = random_fill();
		it.op        = op;
		it.data_byte = SYM_W'(b);
		it.bit_high  = POS_W'(hi);
		it.bit_low   = POS_W'(lo);
		return it;
	endfunction

	function automatic int any_loaded();
		return loaded_list[$urandom_range(loaded_list.size() - 1)];
	endfunction

	// Offer one item, with random idle cycles ahead of it, and hold it until taken
	task automatic send_code(code_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			code_valid <= 1'b0;
			@(posedge clk);
		end
		code       <= it;
		code_valid <= 1'b1;
		@(posedge clk);
		while (code_stall)
			@(posedge clk);
		sb.note_code(it);
		if (it.op != OP_UNUSED)
			sent_items++;
	endtask

	// Stop offering until every queued symbol has come out
	task automatic drain();
		code_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// Build a random full tree rooted at node 0 and load all of it
	task automatic load_tree(int leaves);
		code_item_t batch    [$];
		int         frontier [$];
		bit         taken    [1 << NODE_W];
		int         inner_left;
		int         k;
		int         idx;
		int         c0;
		int         c1;
		taken[0] = 1'b1;
		frontier.push_back(0);
		inner_left = leaves - 1;
		while (inner_left > 0) begin
			k   = $urandom_range(frontier.size() - 1);
			idx = frontier[k];
			frontier.delete(k);
			do c0 = $urandom_range(1, (1 << NODE_W) - 1); while (taken[c0]);
			taken[c0] = 1'b1;
			do c1 = $urandom_range(1, (1 << NODE_W) - 1); while (taken[c1]);
			taken[c1] = 1'b1;
			batch.push_back(load_item(idx, c0, c1, 1'b0, $urandom_range(255)));
			frontier.push_back(c0);
			frontier.push_back(c1);
			inner_left--;
		end
		// a leaf root has its children followed, so point them back at the root
		foreach (frontier[j]) begin
			if (frontier[j] == 0)
				batch.push_back(load_item(0, 0, 0, 1'b1, $urandom_range(255)));
			else
				batch.push_back(load_item(frontier[j], $urandom_range(511),
					$urandom_range(511), 1'b1, $urandom_range(255)));
		end
		foreach (batch[j])
			send_code(batch[j]);
	endtask

	// Overwrite one node; anything that can be followed points at loaded nodes
	task automatic noise_load();
		int idx;
		bit leaf;
		idx  = $urandom_range(511);
		leaf = 1'($urandom_range(1));
		if (!leaf || idx == 0)
			send_code(load_item(idx, any_loaded(), any_loaded(), leaf, $urandom_range(255)));
		else
			send_code(load_item(idx, $urandom_range(511), $urandom_range(511), leaf,
				$urandom_range(255)));
	endtask

	task automatic random_data(bit closing);
		logic [1:0] op;
		int         hi;
		int         lo;
		op = (closing || $urandom_range(99) < 25) ? OP_FINAL : OP_DATA;
		if ($urandom_range(99) < 60) begin
			hi = 7;
			lo = 0;
		end else begin
			hi = $urandom_range(7);
			lo = $urandom_range(7);
		end
		send_code(data_item(op, $urandom_range(255), hi, lo));
	endtask

	initial begin
		int  leaves;
		int  stream_len;
		int  r;
		bit  hold_asked;
		sb         = new();
		hold_asked = 1'b0;
		arst_n     = 1'b0;
		code_valid = 1'b0;
		code       = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Leaf at the root: every bit pays out, a final byte flushes one more
		send_code(load_item(0, 0, 0, 1'b1, 8'hA5));
		send_code(data_item(OP_DATA, 8'h00, 7, 0));
		send_code(data_item(OP_FINAL, 8'hFF, 7, 0));
		send_code(data_item(OP_FINAL, 8'h5A, 0, 7));
		send_code(data_item(OP_UNUSED, 8'hFF, 7, 0));

		// Small tree using the top node index and extreme symbols
		send_code(load_item(0, 511, 5, 1'b0, 8'h00));
		send_code(load_item(511, 511, 511, 1'b1, 8'h00));
		send_code(load_item(5, 6, 7, 1'b0, 8'hFF));
		send_code(load_item(6, 0, 0, 1'b1, 8'hFF));
		send_code(load_item(7, 0, 0, 1'b1, 8'h3C));
		send_code(data_item(OP_DATA, 8'b1011_0100, 7, 0));
		send_code(data_item(OP_DATA, 8'h01, 0, 0));
		send_code(data_item(OP_DATA, 8'hFF, 3, 4));
		send_code(data_item(OP_DATA, 8'hFF, 7, 7));
		send_code(data_item(OP_FINAL, 8'h00, 3, 0));
		send_code(data_item(OP_FINAL, 8'hFF, 7, 0));
		send_code(data_item(OP_FINAL, 8'hC3, 5, 2));
		send_code(data_item(OP_UNUSED, 8'h00, 0, 7));
		drain();

		// Random trees and streams over the four idling phases
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
			default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			while (sent_items < 18 + 48 * (ph + 1)) begin
				r = $urandom_range(99);
				if (r < 8)
					leaves = 1;
				else if (r < 88)
					leaves = $urandom_range(2, 10);
				else
					leaves = $urandom_range(11, 24);
				load_tree(leaves);
				// hold the symbol side off while the stream keeps coming
				if (ph == 0 && !hold_asked && sent_items > 40) begin
					hold_req++;
					hold_asked = 1'b1;
				end
				stream_len = $urandom_range(3, 15);
				for (int s = 0; s < stream_len; s++) begin
					r = $urandom_range(99);
					if (r < 8)
						send_code(data_item(OP_UNUSED, $urandom_range(255),
							$urandom_range(7), $urandom_range(7)));
					else if (r < 16)
						noise_load();
					else
						random_data(s == stream_len - 1);
				end
			end
			drain();
		end

		repeat (30) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d symbols never came out", sb.pending()));
		if (sb.errors == 0)
			$display("** huffman_tree_walk_decoder: PASSED **");
		else
			$display("** huffman_tree_walk_decoder: FAILED **");
		$finish;
	end

endmodule
